// ===== src/assert_macros.svh =====
// assertion macros used by min_tracking_stack
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define ASSERT_RST(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("assertion failed");

// property checked on every rising clock edge, reset included
`define ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");

`endif

// ===== src/mts_pkg.sv =====
// shared types and constants for the min tracking stack
// no dependencies
package mts_pkg;

  localparam int unsigned DEPTH      = 64;
  localparam int unsigned WORD_WIDTH = 32;
  localparam int unsigned CNT_W      = $clog2(DEPTH + 1);

  typedef logic signed [WORD_WIDTH-1:0] word_t;
  typedef logic [CNT_W-1:0]             count_t;

  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_POP  = 1'b1
  } command_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_OVERFLOW  = 2'd2
  } status_e;

  // shift controls broadcast to every cell
  typedef struct packed {
    logic data_push;
    logic data_pop;
    logic min_push;
    logic min_pop;
  } shift_ctrl_t;

endpackage

// ===== src/mts_cell.sv =====
// one entry of the shift stack: a data word and a minimum word
// depends on mts_pkg
module mts_cell (
  input  logic                clk_i,
  input  mts_pkg::shift_ctrl_t ctrl_i,
  input  mts_pkg::word_t      data_above_i,
  input  mts_pkg::word_t      data_below_i,
  input  mts_pkg::word_t      min_above_i,
  input  mts_pkg::word_t      min_below_i,
  output mts_pkg::word_t      data_o,
  output mts_pkg::word_t      min_o
);

  mts_pkg::word_t data_q, data_d;
  mts_pkg::word_t min_q, min_d;

  // push takes the neighbor above, pop takes the neighbor below
  always_comb begin
    data_d = data_q;
    if (ctrl_i.data_push) begin
      data_d = data_above_i;
    end else if (ctrl_i.data_pop) begin
      data_d = data_below_i;
    end
    min_d = min_q;
    if (ctrl_i.min_push) begin
      min_d = min_above_i;
    end else if (ctrl_i.min_pop) begin
      min_d = min_below_i;
    end
  end

  // payload only, no reset
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    min_q  <= min_d;
  end

  assign data_o = data_q;
  assign min_o  = min_q;

endmodule

// ===== src/min_tracking_stack.sv =====
// min tracking stack: the result strobes on done_o the cycle after start_i.
// throughput one transaction per cycle: every operation only shifts the cell chain once,
// so busy_o never rises. the receiver cannot stall and takes each result as it appears.
// reset clears both counts (stack empty) and the strobe; cell contents stay undefined
// and are never read before written.
// depends on mts_pkg, mts_cell and assert_macros.svh
`include "assert_macros.svh"

module min_tracking_stack (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start_i,
  output logic                                   busy_o,
  input  logic                                   command_i,
  input  logic signed [mts_pkg::WORD_WIDTH-1:0]  value_i,
  output logic                                   done_o,
  output logic signed [mts_pkg::WORD_WIDTH-1:0]  popped_value_o,
  output logic signed [mts_pkg::WORD_WIDTH-1:0]  current_min_o,
  output logic                                   is_empty_o,
  output logic [1:0]                             status_o
);

  mts_pkg::count_t      data_count_q, data_count_d;
  mts_pkg::count_t      min_count_q, min_count_d;
  mts_pkg::shift_ctrl_t ctrl;
  mts_pkg::word_t       cell_data [mts_pkg::DEPTH];
  mts_pkg::word_t       cell_min  [mts_pkg::DEPTH];

  logic           accept, is_push, full, empty, min_empty;
  mts_pkg::word_t top_data, top_min;
  mts_pkg::word_t popped_d, min_d;
  mts_pkg::status_e status_d;

  logic           done_q;
  mts_pkg::word_t popped_q, cur_min_q;
  logic           is_empty_q;
  mts_pkg::status_e status_q;

  // never busy: each operation is taken when started and its result is registered
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  assign is_push   = (mts_pkg::command_e'(command_i) == mts_pkg::CMD_PUSH);
  assign full      = (data_count_q == mts_pkg::CNT_W'(mts_pkg::DEPTH));
  assign empty     = (data_count_q == '0);
  assign min_empty = (min_count_q == '0);
  assign top_data  = cell_data[0];
  assign top_min   = cell_min[0];

  // shift decisions from the top cell
  always_comb begin
    ctrl.data_push = accept && is_push && !full;
    ctrl.data_pop  = accept && !is_push && !empty;
    ctrl.min_push  = ctrl.data_push && (min_empty || (value_i <= top_min));
    ctrl.min_pop   = ctrl.data_pop && !min_empty && (top_data == top_min);
  end

  // next counts
  always_comb begin
    data_count_d = data_count_q;
    if (ctrl.data_push) begin
      data_count_d = data_count_q + mts_pkg::CNT_W'(1);
    end else if (ctrl.data_pop) begin
      data_count_d = data_count_q - mts_pkg::CNT_W'(1);
    end
    min_count_d = min_count_q;
    if (ctrl.min_push) begin
      min_count_d = min_count_q + mts_pkg::CNT_W'(1);
    end else if (ctrl.min_pop) begin
      min_count_d = min_count_q - mts_pkg::CNT_W'(1);
    end
  end

  // result fields for the transaction being taken
  always_comb begin
    popped_d = ctrl.data_pop ? top_data : '0;
    if (min_count_d == '0) begin
      min_d = '0;
    end else if (ctrl.min_push) begin
      min_d = value_i;
    end else if (ctrl.min_pop) begin
      min_d = cell_min[1];
    end else begin
      min_d = top_min;
    end
    status_d = mts_pkg::ST_OK;
    if (accept && is_push && full) begin
      status_d = mts_pkg::ST_OVERFLOW;
    end else if (accept && !is_push && empty) begin
      status_d = mts_pkg::ST_UNDERFLOW;
    end
  end

  // cell chain, cell 0 is the top of both stacks
  for (genvar i = 0; i < mts_pkg::DEPTH; i++) begin : g_cell
    mts_pkg::word_t data_above, min_above, data_below, min_below;
    if (i == 0) begin : g_top
      assign data_above = value_i;
      assign min_above  = value_i;
    end else begin : g_mid
      assign data_above = cell_data[i-1];
      assign min_above  = cell_min[i-1];
    end
    if (i == mts_pkg::DEPTH - 1) begin : g_bottom
      assign data_below = '0;
      assign min_below  = '0;
    end else begin : g_up
      assign data_below = cell_data[i+1];
      assign min_below  = cell_min[i+1];
    end
    mts_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .data_above_i (data_above),
      .data_below_i (data_below),
      .min_above_i  (min_above),
      .min_below_i  (min_below),
      .data_o       (cell_data[i]),
      .min_o        (cell_min[i])
    );
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_count_q <= '0;
      min_count_q  <= '0;
      done_q       <= 1'b0;
    end else begin
      data_count_q <= data_count_d;
      min_count_q  <= min_count_d;
      done_q       <= accept;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      popped_q   <= popped_d;
      cur_min_q  <= min_d;
      is_empty_q <= (data_count_d == '0);
      status_q   <= status_d;
    end
  end

  assign done_o         = done_q;
  assign popped_value_o = popped_q;
  assign current_min_o  = cur_min_q;
  assign is_empty_o     = is_empty_q;
  assign status_o       = status_q;

  // checks
  `ASSERT_RST(a_min_within_data, clk_i, rst_ni, min_count_q <= data_count_q)
  `ASSERT_RST(a_count_in_range, clk_i, rst_ni,
              data_count_q <= mts_pkg::CNT_W'(mts_pkg::DEPTH))
  `ASSERT_RST(a_underflow_empty, clk_i, rst_ni,
              (done_o && status_o == mts_pkg::ST_UNDERFLOW) |-> is_empty_o)
  `ASSERT_RST(a_empty_min_zero, clk_i, rst_ni,
              (done_o && is_empty_o) |-> (current_min_o == '0))

endmodule
